[design/btlpm_pkg.sv]
// Shared codes, command and flag types for the binary trie prefix-match core.
`default_nettype none
package btlpm_pkg;

    localparam int DEF_NODE_COUNT = 4096;
    localparam int DEF_VALUE_BITS = 32;
    localparam int ADDR_W         = 32;
    localparam int LEN_W          = 6;
    localparam int MATCH_W        = 32;
    localparam logic [LEN_W-1:0] MAX_DEPTH = 6'd32;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_LK_STEP,
        CMD_WALK_STEP,
        CMD_WORK_LOAD,
        CMD_FULL,
        CMD_POP_RD,
        CMD_ALLOC,
        CMD_FINAL,
        CMD_CLEAR,
        CMD_PAR_RD,
        CMD_PRUNE,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       at_len;
        logic       lvl_max;
        logic       lvl_zero;
        logic       child_zero;
        logic       node_valid;
        logic       work_busy;
        logic       pool_short;
        logic       out_free;
    } dp_flags_t;

endpackage
`default_nettype wire

[design/btlpm_datapath.sv]
// Datapath: node memory, free-node stack, path stack, walk registers and result register.
`default_nettype none
module btlpm_datapath #(
    parameter int NODE_COUNT = btlpm_pkg::DEF_NODE_COUNT,
    parameter int VALUE_BITS = btlpm_pkg::DEF_VALUE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire btlpm_pkg::cmd_t                   cmd,
    output btlpm_pkg::dp_flags_t                   flags,
    input  wire logic [1:0]                        operation,
    input  wire logic [btlpm_pkg::ADDR_W-1:0]      address,
    input  wire logic [btlpm_pkg::LEN_W-1:0]       prefix_len,
    input  wire logic [31:0]                       entry_value,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [1:0]                             status,
    output logic [btlpm_pkg::MATCH_W-1:0]          match_value
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int CW = AW + 1;
    localparam int HW = AW + 2;
    localparam int PD = 32;

    typedef struct packed {
        logic [AW-1:0]         child1;
        logic [AW-1:0]         child0;
        logic                  valid;
        logic [VALUE_BITS-1:0] value;
    } node_t;

    node_t node_mem [NODE_COUNT];
    logic [AW-1:0] fs_mem [NODE_COUNT];
    logic [AW-1:0] path_reg [PD];

    node_t                  node_q;
    node_t                  root_reg, root_next;
    node_t                  work_reg;
    logic [AW-1:0]          fs_q;
    logic [1:0]             op_reg;
    logic [31:0]            addr_reg;
    logic [5:0]             len_reg;
    logic [VALUE_BITS-1:0]  val_reg;
    logic [AW-1:0]          cur_reg;
    logic [5:0]             level_reg;
    logic [AW-1:0]          freed_reg;
    logic [CW-1:0]          free_top_reg;
    logic [CW-1:0]          fresh_reg;
    logic [1:0]             res_status_reg;
    logic [VALUE_BITS-1:0]  res_match_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic [31:0]            out_match_reg;

    node_t          nd;
    node_t          wr_data;
    logic           wr_en;
    logic           rd_en;
    logic [AW-1:0]  rd_idx;
    logic           bit_sel;
    logic [AW-1:0]  child;
    logic [5:0]     lvl_dec;
    logic [AW-1:0]  par_idx;
    logic [5:0]     need;
    logic [HW-1:0]  have;
    logic [AW-1:0]  take_idx;
    logic           fs_nonempty;

    assign nd          = (cur_reg == '0) ? root_reg : node_q;
    assign bit_sel     = addr_reg[~level_reg[4:0]];
    assign child       = bit_sel ? nd.child1 : nd.child0;
    assign lvl_dec     = level_reg - 6'd1;
    assign par_idx     = path_reg[lvl_dec[4:0]];
    assign need        = len_reg - level_reg;
    assign have        = HW'(free_top_reg) + HW'(NODE_COUNT) - HW'(fresh_reg);
    assign fs_nonempty = (free_top_reg != '0);
    assign take_idx    = fs_nonempty ? fs_q : fresh_reg[AW-1:0];

    assign flags.op         = op_reg;
    assign flags.at_len     = (level_reg == len_reg);
    assign flags.lvl_max    = (level_reg == btlpm_pkg::MAX_DEPTH);
    assign flags.lvl_zero   = (level_reg == '0);
    assign flags.child_zero = (child == '0);
    assign flags.node_valid = nd.valid;
    assign flags.work_busy  = work_reg.valid | (work_reg.child0 != '0) | (work_reg.child1 != '0);
    assign flags.pool_short = (HW'(need) > have);
    assign flags.out_free   = !out_valid_reg || out_ready;

    // node write and read selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = work_reg;
        rd_en   = 1'b0;
        rd_idx  = child;
        unique case (cmd)
            btlpm_pkg::CMD_ALLOC:
            begin
                wr_en = 1'b1;
                if (bit_sel)
                begin
                    wr_data.child1 = take_idx;
                end
                else
                begin
                    wr_data.child0 = take_idx;
                end
            end
            btlpm_pkg::CMD_FINAL:
            begin
                wr_en         = 1'b1;
                wr_data.valid = 1'b1;
                wr_data.value = val_reg;
            end
            btlpm_pkg::CMD_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_data       = nd;
                wr_data.valid = 1'b0;
                wr_data.value = '0;
            end
            btlpm_pkg::CMD_PRUNE:
            begin
                wr_en   = 1'b1;
                wr_data = nd;
                if (bit_sel)
                begin
                    wr_data.child1 = '0;
                end
                else
                begin
                    wr_data.child0 = '0;
                end
            end
            btlpm_pkg::CMD_LK_STEP, btlpm_pkg::CMD_WALK_STEP:
            begin
                rd_en = 1'b1;
            end
            btlpm_pkg::CMD_PAR_RD:
            begin
                rd_en  = 1'b1;
                rd_idx = par_idx;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        root_next = root_reg;
        if (wr_en && (cur_reg == '0))
        begin
            root_next = wr_data;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (wr_en && (cur_reg != '0))
        begin
            node_mem[cur_reg] <= wr_data;
        end
        if (rd_en)
        begin
            node_q <= node_mem[rd_idx];
        end
        if (cmd == btlpm_pkg::CMD_POP_RD)
        begin
            fs_q <= fs_mem[AW'(free_top_reg - CW'(1))];
        end
        if ((cmd == btlpm_pkg::CMD_PRUNE) && (free_top_reg < CW'(NODE_COUNT)))
        begin
            fs_mem[free_top_reg[AW-1:0]] <= freed_reg;
        end
    end

    // control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg      <= '0;
            free_top_reg  <= '0;
            fresh_reg     <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            root_reg <= root_next;
            if (cmd == btlpm_pkg::CMD_ALLOC)
            begin
                if (fs_nonempty)
                begin
                    free_top_reg <= free_top_reg - CW'(1);
                end
                else
                begin
                    fresh_reg <= fresh_reg + CW'(1);
                end
            end
            if ((cmd == btlpm_pkg::CMD_PRUNE) && (free_top_reg < CW'(NODE_COUNT)))
            begin
                free_top_reg <= free_top_reg + CW'(1);
            end
            if (cmd == btlpm_pkg::CMD_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            btlpm_pkg::CMD_LOAD:
            begin
                op_reg         <= operation;
                addr_reg       <= address;
                len_reg        <= (prefix_len > btlpm_pkg::MAX_DEPTH) ? btlpm_pkg::MAX_DEPTH
                                                                      : prefix_len;
                val_reg        <= VALUE_BITS'(entry_value);
                cur_reg        <= '0;
                level_reg      <= '0;
                res_status_reg <= btlpm_pkg::ST_MISS;
                res_match_reg  <= '0;
            end
            btlpm_pkg::CMD_LK_STEP:
            begin
                if (nd.valid)
                begin
                    res_status_reg <= btlpm_pkg::ST_HIT;
                    res_match_reg  <= nd.value;
                end
                cur_reg   <= child;
                level_reg <= level_reg + 6'd1;
            end
            btlpm_pkg::CMD_WALK_STEP:
            begin
                path_reg[level_reg[4:0]] <= cur_reg;
                cur_reg                  <= child;
                level_reg                <= level_reg + 6'd1;
            end
            btlpm_pkg::CMD_WORK_LOAD:
            begin
                work_reg <= nd;
            end
            btlpm_pkg::CMD_FULL:
            begin
                res_status_reg <= btlpm_pkg::ST_FULL;
            end
            btlpm_pkg::CMD_ALLOC:
            begin
                work_reg  <= '0;
                cur_reg   <= take_idx;
                level_reg <= level_reg + 6'd1;
            end
            btlpm_pkg::CMD_FINAL:
            begin
                res_status_reg <= btlpm_pkg::ST_HIT;
            end
            btlpm_pkg::CMD_CLEAR:
            begin
                work_reg       <= wr_data;
                res_status_reg <= btlpm_pkg::ST_HIT;
            end
            btlpm_pkg::CMD_PAR_RD:
            begin
                freed_reg <= cur_reg;
                cur_reg   <= par_idx;
                level_reg <= lvl_dec;
            end
            btlpm_pkg::CMD_PRUNE:
            begin
                work_reg <= wr_data;
            end
            btlpm_pkg::CMD_EMIT:
            begin
                out_status_reg <= res_status_reg;
                out_match_reg  <= 32'(res_match_reg);
            end
            default:
            begin
                work_reg <= work_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign match_value = out_match_reg;

endmodule
`default_nettype wire

[design/btlpm_ctrl.sv]
// Controller: sequences lookup, insert and delete walks over the datapath.
`default_nettype none
module btlpm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire btlpm_pkg::dp_flags_t flags,
    output btlpm_pkg::cmd_t           cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_LK   = 4'd2;
    localparam logic [3:0] S_IW   = 4'd3;
    localparam logic [3:0] S_ICK  = 4'd4;
    localparam logic [3:0] S_ARD  = 4'd5;
    localparam logic [3:0] S_AWR  = 4'd6;
    localparam logic [3:0] S_DW   = 4'd7;
    localparam logic [3:0] S_DCL  = 4'd8;
    localparam logic [3:0] S_PR   = 4'd9;
    localparam logic [3:0] S_PW   = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = btlpm_pkg::CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = btlpm_pkg::CMD_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority case (flags.op)
                    btlpm_pkg::OP_LOOKUP: state_next = S_LK;
                    btlpm_pkg::OP_INSERT: state_next = S_IW;
                    btlpm_pkg::OP_DELETE: state_next = S_DW;
                    default:              state_next = S_DONE;
                endcase
            end
            S_LK:
            begin
                cmd = btlpm_pkg::CMD_LK_STEP;
                if (flags.lvl_max || flags.child_zero)
                begin
                    state_next = S_DONE;
                end
            end
            S_IW:
            begin
                if (flags.at_len || flags.child_zero)
                begin
                    state_next = S_ICK;
                end
                else
                begin
                    cmd = btlpm_pkg::CMD_WALK_STEP;
                end
            end
            S_ICK:
            begin
                if (flags.pool_short)
                begin
                    cmd        = btlpm_pkg::CMD_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = btlpm_pkg::CMD_WORK_LOAD;
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                if (flags.at_len)
                begin
                    cmd        = btlpm_pkg::CMD_FINAL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = btlpm_pkg::CMD_POP_RD;
                    state_next = S_AWR;
                end
            end
            S_AWR:
            begin
                cmd        = btlpm_pkg::CMD_ALLOC;
                state_next = S_ARD;
            end
            S_DW:
            begin
                if (flags.at_len)
                begin
                    state_next = flags.node_valid ? S_DCL : S_DONE;
                end
                else if (flags.child_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd = btlpm_pkg::CMD_WALK_STEP;
                end
            end
            S_DCL:
            begin
                cmd        = btlpm_pkg::CMD_CLEAR;
                state_next = S_PR;
            end
            S_PR:
            begin
                if (flags.lvl_zero || flags.work_busy)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = btlpm_pkg::CMD_PAR_RD;
                    state_next = S_PW;
                end
            end
            S_PW:
            begin
                cmd        = btlpm_pkg::CMD_PRUNE;
                state_next = S_PR;
            end
            S_DONE:
            begin
                if (flags.out_free)
                begin
                    cmd        = btlpm_pkg::CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[design/binary_trie_longest_prefix_match_core.sv]
// Top level of the binary trie longest-prefix-match core.
// IPv4 route table held as a one-bit-per-level binary trie. One transaction is
// taken at a time: a lookup walks the trie one node per cycle (one registered
// read of the node memory each step) until the last level or a missing child.
// An insert walks the existing path, checks the node pool, then reads the free
// stack and writes the node for each new node. A delete walks the path, clears
// the value, then prunes back, reading the parent and clearing its link for
// each freed node. The node memory read port sets the walk rate. A new
// transaction is taken while the previous result still waits at the output.
// No clearing pass is needed after reset: the root lives in flip-flops and
// every other node is written when it is allocated.
`default_nettype none
module binary_trie_longest_prefix_match_core #(
    parameter int NODE_COUNT = btlpm_pkg::DEF_NODE_COUNT,
    parameter int VALUE_BITS = btlpm_pkg::DEF_VALUE_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   operation,
    input  wire logic [btlpm_pkg::ADDR_W-1:0] address,
    input  wire logic [btlpm_pkg::LEN_W-1:0]  prefix_len,
    input  wire logic [31:0]                  entry_value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        status,
    output logic [btlpm_pkg::MATCH_W-1:0]     match_value
);

    btlpm_pkg::cmd_t      cmd;
    btlpm_pkg::dp_flags_t flags;

    // sequence the walk
    btlpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .flags    (flags),
        .cmd      (cmd)
    );

    // hold the trie, the free stack and the result register
    btlpm_datapath #(
        .NODE_COUNT (NODE_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .flags       (flags),
        .operation   (operation),
        .address     (address),
        .prefix_len  (prefix_len),
        .entry_value (entry_value),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .status      (status),
        .match_value (match_value)
    );

endmodule
`default_nettype wire

[design/btlpm_checker.sv]
// Port-level checker for the prefix-match core, bound to the top level.
`default_nettype none
module btlpm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [31:0] match_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(match_value))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == btlpm_pkg::ST_HIT) || (status == btlpm_pkg::ST_MISS)
                      || (status == btlpm_pkg::ST_FULL))
        else $error("undefined status code");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != btlpm_pkg::ST_HIT) |-> match_value == 32'd0)
        else $error("non-zero value on a miss");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

endmodule

bind binary_trie_longest_prefix_match_core btlpm_checker u_btlpm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .match_value (match_value)
);
`default_nettype wire
